/* rtl/mas_pkg.sv */
// ----------------------------------------------------------------------------
// Multi-alarm scheduler package
// Shared types, codes and sizes for the alarm scheduler controller and datapath.
// ----------------------------------------------------------------------------
package mas_pkg;

    localparam int MAX_ALARMS         = 16;
    localparam int IDX_W              = $clog2(MAX_ALARMS);
    localparam int CNT_W              = $clog2(MAX_ALARMS + 1);
    localparam int RING_TIMEOUT_RESET = 600;
    localparam int SEC_PER_MIN        = 60;
    localparam int NOW_W              = 40;
    localparam int KEY_W              = 35;
    localparam int DIV_DIGIT_W        = 10;
    localparam int DIV_STEPS          = NOW_W / DIV_DIGIT_W;
    localparam int DIV_CNT_W          = $clog2(DIV_STEPS + 1);
    localparam int DIV_RECIP          = 34953;
    localparam int DIV_SHIFT          = 21;

    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_ADD     = 3'd1;
    localparam logic [2:0] REQ_UPDATE  = 3'd2;
    localparam logic [2:0] REQ_REMOVE  = 3'd3;
    localparam logic [2:0] REQ_ENABLE  = 3'd4;
    localparam logic [2:0] REQ_DISMISS = 3'd5;
    localparam logic [2:0] REQ_SNOOZE  = 3'd6;
    localparam logic [2:0] REQ_UNKNOWN = 3'd7;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_INVALID     = 3'd1;
    localparam logic [2:0] ST_FULL        = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
    localparam logic [2:0] ST_NOT_RINGING = 3'd4;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [31:0]      alarm_id;
        logic [4:0]       hour_value;
        logic [5:0]       minute_value;
        logic [7:0]       day_mask;
        logic             enable_flag;
        logic [15:0]      snooze_minutes;
        logic [NOW_W-1:0] now_seconds;
        logic [2:0]       weekday;
        logic             time_valid;
    } t_req;

    typedef struct packed {
        logic [2:0]       status;
        logic [31:0]      new_id;
        logic             ringing;
        logic [31:0]      active_id;
        logic [4:0]       shown_hour;
        logic [5:0]       shown_minute;
        logic             sound_start;
        logic             sound_stop;
        logic [CNT_W-1:0] entry_count;
        logic [CNT_W-1:0] enabled_total;
        logic             changed;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_WALK,
        S_EXEC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic latch;
        logic div_step;
        logic walk_step;
        logic exec;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic tick_live;
        logic div_done;
        logic need_walk;
        logic walk_done;
    } t_sts;

endpackage

/* rtl/mas_ctrl.sv */
// ----------------------------------------------------------------------------
// Multi-alarm scheduler controller
// Sequences each request through division, table walk, execute and result.
// ----------------------------------------------------------------------------
module mas_ctrl import mas_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_sts   i_sts,
    output t_cmd   o_cmd,
    output logic   o_busy,
    output t_state o_state
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.tick_live && !i_sts.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.need_walk && !i_sts.walk_done) begin
                    o_cmd.walk_step = 1'b1;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

/* rtl/mas_dp.sv */
// ----------------------------------------------------------------------------
// Multi-alarm scheduler datapath
// Alarm table, ring and snooze state, minute divider and result register.
// ----------------------------------------------------------------------------
module mas_dp import mas_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_req        i_req,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output t_sts        o_sts,
    output t_res        o_res,
    output logic        o_res_valid
);

    logic [31:0]      r_id     [MAX_ALARMS];
    logic [4:0]       r_hour   [MAX_ALARMS];
    logic [5:0]       r_min    [MAX_ALARMS];
    logic             r_en     [MAX_ALARMS];
    logic [6:0]       r_days   [MAX_ALARMS];
    logic [KEY_W-1:0] r_last   [MAX_ALARMS];
    logic [CNT_W-1:0] r_count;
    logic [31:0]      r_next_id;
    logic             r_ring;
    logic [31:0]      r_ring_id;
    logic [4:0]       r_ring_hour;
    logic [5:0]       r_ring_min;
    logic [NOW_W-1:0] r_ring_start;
    logic [NOW_W:0]   r_snz_due;
    logic [31:0]      r_snz_id;
    logic [15:0]      r_max;

    t_req             r_req;
    logic [NOW_W-1:0] r_num;
    logic [NOW_W-1:0] r_quo;
    logic [5:0]       r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [CNT_W-1:0] r_k;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    t_res             r_res;
    logic             r_vld;

    logic [IDX_W-1:0] k_idx;
    logic [15:0]      div_t;
    logic [30:0]      div_prod;
    logic [DIV_DIGIT_W-1:0] div_qd;
    logic [15:0]      div_rem;
    logic [KEY_W-1:0] key;
    logic             args_ok;
    logic             t_stop;
    logic             ring_after;
    logic             snz_fire;
    logic             scan_en;
    logic             id_match;
    logic             scan_match;
    logic [31:0]      next_inc;
    logic [21:0]      snz_sec;
    logic [CNT_W-1:0] en_total;
    logic [CNT_W-1:0] last_pos;

    assign k_idx    = r_k[IDX_W-1:0];
    assign div_t    = {r_rem, r_num[NOW_W-1 -: DIV_DIGIT_W]};
    assign div_prod = 31'(div_t) * 31'(DIV_RECIP);
    assign div_qd   = div_prod[DIV_SHIFT +: DIV_DIGIT_W];
    assign div_rem  = div_t - 16'(div_qd) * 16'(SEC_PER_MIN);
    assign key      = r_quo[KEY_W-1:0];

    assign args_ok = (r_req.hour_value < 5'd24) && (r_req.minute_value < 6'd60)
                     && !r_req.day_mask[7];

    assign t_stop = r_ring && (r_ring_start != '0) && (r_req.now_seconds >= r_ring_start)
                    && ((r_req.now_seconds - r_ring_start) >= {24'd0, r_max});
    assign ring_after = r_ring && !t_stop;
    assign snz_fire   = !ring_after && (r_snz_due != '0)
                        && ({1'b0, r_req.now_seconds} >= r_snz_due);
    assign scan_en    = !ring_after && !snz_fire;

    assign id_match   = (r_id[k_idx] == r_req.alarm_id);
    assign scan_match = r_en[k_idx] && (r_hour[k_idx] == r_req.hour_value)
                        && (r_min[k_idx] == r_req.minute_value)
                        && ((r_days[k_idx] == '0)
                            || (({1'b0, r_days[k_idx]} >> r_req.weekday) & 8'd1) != 8'd0)
                        && (r_last[k_idx] != key);

    assign next_inc = r_next_id + 32'd1;
    assign snz_sec  = 22'(r_req.snooze_minutes) * 22'(SEC_PER_MIN);
    assign last_pos = r_count - CNT_W'(1);

    always_comb begin
        en_total = '0;
        for (int i = 0; i < MAX_ALARMS; i++) begin
            en_total = en_total + CNT_W'(r_en[i]);
        end
    end

    assign o_sts.tick_live = (r_req.req_type == REQ_TICK) && r_req.time_valid;
    assign o_sts.div_done  = (r_div_cnt == DIV_CNT_W'(DIV_STEPS));
    assign o_sts.need_walk = (o_sts.tick_live && scan_en)
                             || (r_req.req_type == REQ_UPDATE)
                             || (r_req.req_type == REQ_REMOVE)
                             || (r_req.req_type == REQ_ENABLE);
    assign o_sts.walk_done = (r_k == r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req     <= i_req;
            r_num     <= i_req.now_seconds;
            r_quo     <= '0;
            r_rem     <= '0;
            r_div_cnt <= '0;
            r_k       <= '0;
            r_hit     <= 1'b0;
            r_hit_idx <= '0;
        end
        if (i_cmd.div_step) begin
            r_num     <= r_num << DIV_DIGIT_W;
            r_quo     <= {r_quo[NOW_W-DIV_DIGIT_W-1:0], div_qd};
            r_rem     <= div_rem[5:0];
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.walk_step) begin
            r_k <= r_k + CNT_W'(1);
            if (r_req.req_type == REQ_TICK) begin
                if (scan_match && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= k_idx;
                end
            end else if (id_match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= k_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ALARMS; i++) begin
                r_id[i]   <= '0;
                r_hour[i] <= '0;
                r_min[i]  <= '0;
                r_en[i]   <= 1'b0;
                r_days[i] <= '0;
                r_last[i] <= '0;
            end
            r_count      <= '0;
            r_next_id    <= 32'd1;
            r_ring       <= 1'b0;
            r_ring_id    <= '0;
            r_ring_hour  <= '0;
            r_ring_min   <= '0;
            r_ring_start <= '0;
            r_snz_due    <= '0;
            r_snz_id     <= '0;
            r_max        <= 16'(RING_TIMEOUT_RESET);
            r_vld        <= 1'b0;
        end else begin
            r_vld <= 1'b0;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (i_cmd.walk_step && (r_req.req_type == REQ_TICK) && scan_match) begin
                r_last[k_idx] <= key;
            end
            if (i_cmd.exec) begin
                r_res.status      <= ST_OK;
                r_res.new_id      <= '0;
                r_res.sound_start <= 1'b0;
                r_res.sound_stop  <= 1'b0;
                r_res.changed     <= 1'b0;
                case (r_req.req_type)
                    REQ_TICK: begin
                        if (r_req.time_valid) begin
                            if (t_stop) begin
                                r_ring       <= 1'b0;
                                r_ring_id    <= '0;
                                r_ring_start <= '0;
                                r_res.sound_stop <= 1'b1;
                                r_res.changed    <= 1'b1;
                            end
                            if (snz_fire) begin
                                r_ring       <= 1'b1;
                                r_ring_id    <= r_snz_id;
                                r_ring_hour  <= r_req.hour_value;
                                r_ring_min   <= r_req.minute_value;
                                r_ring_start <= r_req.now_seconds;
                                r_snz_due    <= '0;
                                r_snz_id     <= '0;
                                r_res.sound_start <= 1'b1;
                                r_res.changed     <= 1'b1;
                            end else if (scan_en && r_hit) begin
                                if (r_days[r_hit_idx] == '0) begin
                                    r_en[r_hit_idx] <= 1'b0;
                                end
                                r_ring       <= 1'b1;
                                r_ring_id    <= r_id[r_hit_idx];
                                r_ring_hour  <= r_hour[r_hit_idx];
                                r_ring_min   <= r_min[r_hit_idx];
                                r_ring_start <= r_req.now_seconds;
                                r_res.sound_start <= 1'b1;
                                r_res.changed     <= 1'b1;
                            end
                        end
                    end
                    REQ_ADD: begin
                        if (!args_ok) begin
                            r_res.status <= ST_INVALID;
                        end else if (r_count >= CNT_W'(MAX_ALARMS)) begin
                            r_res.status <= ST_FULL;
                        end else begin
                            r_id[r_count[IDX_W-1:0]]   <= r_next_id;
                            r_hour[r_count[IDX_W-1:0]] <= r_req.hour_value;
                            r_min[r_count[IDX_W-1:0]]  <= r_req.minute_value;
                            r_days[r_count[IDX_W-1:0]] <= r_req.day_mask[6:0];
                            r_en[r_count[IDX_W-1:0]]   <= 1'b1;
                            r_count       <= r_count + CNT_W'(1);
                            r_next_id     <= (next_inc == '0) ? 32'd1 : next_inc;
                            r_res.new_id  <= r_next_id;
                            r_res.changed <= 1'b1;
                        end
                    end
                    REQ_UPDATE: begin
                        if (!args_ok) begin
                            r_res.status <= ST_INVALID;
                        end else if (!r_hit) begin
                            r_res.status <= ST_NOT_FOUND;
                        end else begin
                            r_hour[r_hit_idx] <= r_req.hour_value;
                            r_min[r_hit_idx]  <= r_req.minute_value;
                            r_days[r_hit_idx] <= r_req.day_mask[6:0];
                            r_last[r_hit_idx] <= '0;
                            r_res.changed     <= 1'b1;
                        end
                    end
                    REQ_REMOVE: begin
                        if (!r_hit) begin
                            r_res.status <= ST_NOT_FOUND;
                        end else begin
                            for (int i = 0; i < MAX_ALARMS - 1; i++) begin
                                if ((IDX_W'(i) >= r_hit_idx)
                                    && (CNT_W'(i + 1) < r_count)) begin
                                    r_id[i]   <= r_id[i+1];
                                    r_hour[i] <= r_hour[i+1];
                                    r_min[i]  <= r_min[i+1];
                                    r_en[i]   <= r_en[i+1];
                                    r_days[i] <= r_days[i+1];
                                    r_last[i] <= r_last[i+1];
                                end
                            end
                            r_id[last_pos[IDX_W-1:0]]   <= '0;
                            r_hour[last_pos[IDX_W-1:0]] <= '0;
                            r_min[last_pos[IDX_W-1:0]]  <= '0;
                            r_en[last_pos[IDX_W-1:0]]   <= 1'b0;
                            r_days[last_pos[IDX_W-1:0]] <= '0;
                            r_last[last_pos[IDX_W-1:0]] <= '0;
                            r_count <= last_pos;
                            if (r_ring && (r_ring_id == r_req.alarm_id)) begin
                                r_ring       <= 1'b0;
                                r_ring_id    <= '0;
                                r_ring_start <= '0;
                                r_res.sound_stop <= 1'b1;
                            end
                            if (r_snz_id == r_req.alarm_id) begin
                                r_snz_id  <= '0;
                                r_snz_due <= '0;
                            end
                            r_res.changed <= 1'b1;
                        end
                    end
                    REQ_ENABLE: begin
                        if (!r_hit) begin
                            r_res.status <= ST_NOT_FOUND;
                        end else begin
                            r_en[r_hit_idx]   <= r_req.enable_flag;
                            r_last[r_hit_idx] <= '0;
                            if (!r_req.enable_flag && r_ring
                                && (r_ring_id == r_req.alarm_id)) begin
                                r_ring       <= 1'b0;
                                r_ring_id    <= '0;
                                r_ring_start <= '0;
                                r_res.sound_stop <= 1'b1;
                            end
                            if (!r_req.enable_flag && (r_snz_id == r_req.alarm_id)) begin
                                r_snz_id  <= '0;
                                r_snz_due <= '0;
                            end
                            r_res.changed <= 1'b1;
                        end
                    end
                    REQ_DISMISS: begin
                        r_ring       <= 1'b0;
                        r_ring_id    <= '0;
                        r_ring_start <= '0;
                        r_snz_due    <= '0;
                        r_snz_id     <= '0;
                        r_res.sound_stop <= 1'b1;
                        r_res.changed    <= 1'b1;
                    end
                    REQ_SNOOZE: begin
                        if (r_req.snooze_minutes == '0) begin
                            r_res.status <= ST_INVALID;
                        end else if (!r_ring) begin
                            r_res.status <= ST_NOT_RINGING;
                        end else begin
                            r_snz_due    <= {1'b0, r_req.now_seconds}
                                            + (NOW_W+1)'(snz_sec);
                            r_snz_id     <= r_ring_id;
                            r_ring       <= 1'b0;
                            r_ring_id    <= '0;
                            r_ring_start <= '0;
                            r_res.sound_stop <= 1'b1;
                            r_res.changed    <= 1'b1;
                        end
                    end
                    default: begin
                        r_res.status <= ST_INVALID;
                    end
                endcase
            end
            if (i_cmd.emit) begin
                r_res.ringing      <= r_ring;
                r_res.active_id    <= r_ring ? r_ring_id : '0;
                r_res.shown_hour   <= r_ring ? r_ring_hour : '0;
                r_res.shown_minute <= r_ring ? r_ring_min : '0;
                r_res.entry_count   <= r_count;
                r_res.enabled_total <= en_total;
                r_vld               <= 1'b1;
            end
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_vld;

endmodule

/* rtl/multi_alarm_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// Multi-alarm scheduler unit
// Sixteen-entry alarm table with tick scanning, ringing, snooze and timeout.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and its one result
// beat appears on o_res for a single cycle with o_res_valid high; the receiver
// cannot stall it, so it must take every beat. A tick with valid time that
// scans the table first divides the epoch seconds by sixty in four ten-bit
// steps by reciprocal multiplication, then walks the stored entries of the
// table one entry per cycle. A valid tick that does not scan still divides
// but skips the walk. Update, remove and set enabled walk the table without
// dividing; other requests do neither. A new request can be started in the
// cycle its predecessor's result is shown.
module multi_alarm_scheduler_unit import mas_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output t_res        o_res,
    output logic        o_res_valid
);

    t_cmd   cmd;
    t_sts   sts;
    t_state state;

    mas_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_state (state)
    );

    mas_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_sts       (sts),
        .o_res       (o_res),
        .o_res_valid (o_res_valid)
    );

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted request did not raise busy.");

    a_valid_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(state == S_EMIT))
        else $error("Result beat without an emit cycle.");

    a_silent_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.ringing) |-> (o_res.active_id == '0))
        else $error("Active id shown while silent.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.enabled_total <= o_res.entry_count))
        else $error("More enabled alarms than stored.");

endmodule

/* tb/multi_alarm_scheduler_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-alarm scheduler unit testbench
// Drives a mix of directed and random requests (tick, add, update, remove,
// enable, dismiss, snooze) with random idle gaps and ring timeout changes.
// A scoreboard keeps its own alarm table and checks every result beat.
// ----------------------------------------------------------------------------
module multi_alarm_scheduler_unit_test;
    import mas_pkg::*;

    class alarm_scoreboard;
        logic [31:0] ident [MAX_ALARMS];
        logic [4:0]  hr_tab [MAX_ALARMS];
        logic [5:0]  mn_tab [MAX_ALARMS];
        logic        en_tab [MAX_ALARMS];
        logic [6:0]  day_tab [MAX_ALARMS];
        logic [KEY_W-1:0] fired_tab [MAX_ALARMS];
        int          count;
        logic [31:0] next_id;
        logic        ring;
        logic [31:0] ring_id;
        logic [4:0]  ring_hr;
        logic [5:0]  ring_mn;
        logic [39:0] ring_t0;
        logic [40:0] snooze_due;
        logic [31:0] snooze_id;
        logic [15:0] timeout;
        t_res        pending [$];
        int          errors;

        function new();
            for (int k = 0; k < MAX_ALARMS; k++) begin
                ident[k] = 0; hr_tab[k] = 0; mn_tab[k] = 0; en_tab[k] = 0;
                day_tab[k] = 0; fired_tab[k] = 0;
            end
            count = 0; next_id = 1; ring = 0; ring_id = 0; ring_hr = 0;
            ring_mn = 0; ring_t0 = 0; snooze_due = 0; snooze_id = 0;
            timeout = RING_TIMEOUT_RESET; errors = 0;
        endfunction

        function int find(logic [31:0] id);
            for (int k = 0; k < count; k++)
                if (ident[k] == id) return k;
            return -1;
        endfunction

        function void silence();
            ring = 0; ring_id = 0; ring_t0 = 0;
        endfunction

        function void note_request(t_req r);
            t_res   e;
            int     idx;
            int     first;
            logic [KEY_W-1:0] key;
            logic   ok_args;
            e = '0;
            ok_args = r.hour_value < 24 && r.minute_value < 60 && !r.day_mask[7];
            case (r.req_type)
                REQ_TICK: if (r.time_valid) begin
                    if (ring && ring_t0 > 0 && r.now_seconds >= ring_t0 &&
                        r.now_seconds - ring_t0 >= timeout) begin
                        silence(); e.sound_stop = 1; e.changed = 1;
                    end
                    if (!ring && snooze_due > 0 && {1'b0, r.now_seconds} >= snooze_due) begin
                        ring = 1; ring_id = snooze_id; ring_hr = r.hour_value;
                        ring_mn = r.minute_value; ring_t0 = r.now_seconds;
                        snooze_due = 0; snooze_id = 0;
                        e.sound_start = 1; e.changed = 1;
                    end else if (!ring) begin
                        key = KEY_W'(r.now_seconds / 60);
                        first = -1;
                        for (int k = 0; k < count; k++)
                            if (en_tab[k] && hr_tab[k] == r.hour_value &&
                                mn_tab[k] == r.minute_value &&
                                (day_tab[k] == 0 || day_tab[k][r.weekday]) &&
                                fired_tab[k] != key) begin
                                fired_tab[k] = key;
                                if (first < 0) first = k;
                            end
                        if (first >= 0) begin
                            if (day_tab[first] == 0) en_tab[first] = 0;
                            ring = 1; ring_id = ident[first]; ring_hr = hr_tab[first];
                            ring_mn = mn_tab[first]; ring_t0 = r.now_seconds;
                            e.sound_start = 1; e.changed = 1;
                        end
                    end
                end
                REQ_ADD: begin
                    if (!ok_args) e.status = ST_INVALID;
                    else if (count >= MAX_ALARMS) e.status = ST_FULL;
                    else begin
                        ident[count] = next_id; e.new_id = next_id;
                        next_id++;
                        if (next_id == 0) next_id = 1;
                        hr_tab[count] = r.hour_value; mn_tab[count] = r.minute_value;
                        day_tab[count] = r.day_mask[6:0]; en_tab[count] = 1;
                        count++; e.changed = 1;
                    end
                end
                REQ_UPDATE: begin
                    idx = find(r.alarm_id);
                    if (!ok_args) e.status = ST_INVALID;
                    else if (idx < 0) e.status = ST_NOT_FOUND;
                    else begin
                        hr_tab[idx] = r.hour_value; mn_tab[idx] = r.minute_value;
                        day_tab[idx] = r.day_mask[6:0]; fired_tab[idx] = 0;
                        e.changed = 1;
                    end
                end
                REQ_REMOVE: begin
                    idx = find(r.alarm_id);
                    if (idx < 0) e.status = ST_NOT_FOUND;
                    else begin
                        e.sound_stop = ring && ring_id == r.alarm_id;
                        for (int k = idx; k + 1 < count; k++) begin
                            ident[k] = ident[k+1]; hr_tab[k] = hr_tab[k+1];
                            mn_tab[k] = mn_tab[k+1]; en_tab[k] = en_tab[k+1];
                            day_tab[k] = day_tab[k+1]; fired_tab[k] = fired_tab[k+1];
                        end
                        count--;
                        ident[count] = 0; hr_tab[count] = 0; mn_tab[count] = 0;
                        en_tab[count] = 0; day_tab[count] = 0; fired_tab[count] = 0;
                        if (e.sound_stop) silence();
                        if (snooze_id == r.alarm_id) begin
                            snooze_id = 0; snooze_due = 0;
                        end
                        e.changed = 1;
                    end
                end
                REQ_ENABLE: begin
                    idx = find(r.alarm_id);
                    if (idx < 0) e.status = ST_NOT_FOUND;
                    else begin
                        en_tab[idx] = r.enable_flag; fired_tab[idx] = 0;
                        if (!r.enable_flag && ring && ring_id == r.alarm_id) begin
                            silence(); e.sound_stop = 1;
                        end
                        if (!r.enable_flag && snooze_id == r.alarm_id) begin
                            snooze_id = 0; snooze_due = 0;
                        end
                        e.changed = 1;
                    end
                end
                REQ_DISMISS: begin
                    silence(); snooze_due = 0; snooze_id = 0;
                    e.sound_stop = 1; e.changed = 1;
                end
                REQ_SNOOZE: begin
                    if (r.snooze_minutes == 0) e.status = ST_INVALID;
                    else if (!ring) e.status = ST_NOT_RINGING;
                    else begin
                        snooze_due = {1'b0, r.now_seconds} + 41'(r.snooze_minutes) * 60;
                        snooze_id = ring_id; silence();
                        e.sound_stop = 1; e.changed = 1;
                    end
                end
                default: e.status = ST_INVALID;
            endcase
            e.ringing = ring;
            e.active_id = ring ? ring_id : 0;
            e.shown_hour = ring ? ring_hr : 0;
            e.shown_minute = ring ? ring_mn : 0;
            e.entry_count = CNT_W'(count);
            e.enabled_total = 0;
            for (int k = 0; k < count; k++) e.enabled_total += en_tab[k];
            pending.push_back(e);
        endfunction

        function void check_result(t_res got);
            t_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat %h", $realtime, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                $display("%0t: mismatch expected %p actual %p", $realtime, e, got);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    t_res        o_res;
    logic        o_res_valid;

    alarm_scoreboard board;
    int          quiet_cycles = 0;
    logic        idle_ok;
    logic [39:0] clock_now;
    logic [31:0] last_id;

    multi_alarm_scheduler_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_res(o_res), .o_res_valid(o_res_valid)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) board.check_result(o_res);
        if (i_rst_n && ((start && !busy) || o_res_valid)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send(t_req r);
        @(negedge i_clk);
        i_req = r;
        start = 1;
        do @(posedge i_clk); while (busy);
        board.note_request(r);
        @(negedge i_clk);
        start = 0;
    endtask

    task automatic maybe_gap();
        if (idle_ok && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
    endtask

    task automatic drain();
        while (board.pending.size() > 0) @(posedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 0;
        board.timeout = v;
    endtask

    function automatic t_req rand_req();
        t_req r;
        int   pick;
        r = '0;
        r.alarm_id = ($urandom_range(0, 9) == 0) ? $urandom
                   : last_id - $urandom_range(0, 18);
        r.hour_value = 5'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                          : $urandom_range(6, 8));
        r.minute_value = 6'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                            : $urandom_range(0, 3));
        r.day_mask = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                        : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 127)));
        r.enable_flag = 1'($urandom_range(0, 1));
        r.snooze_minutes = 16'(($urandom_range(0, 9) == 0) ? $urandom
                              : $urandom_range(0, 3));
        r.weekday = 3'($urandom_range(0, 6));
        r.time_valid = $urandom_range(0, 15) != 0;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            r.req_type = REQ_TICK;
            if ($urandom_range(0, 29) == 0) clock_now = 40'({$urandom, $urandom});
            else if ($urandom_range(0, 19) == 0) clock_now = clock_now - 40'd100;
            else clock_now = clock_now + 40'($urandom_range(0, 200));
            r.now_seconds = clock_now;
        end else begin
            r.now_seconds = clock_now;
            if (pick < 62) r.req_type = REQ_ADD;
            else if (pick < 70) r.req_type = REQ_UPDATE;
            else if (pick < 77) r.req_type = REQ_REMOVE;
            else if (pick < 85) r.req_type = REQ_ENABLE;
            else if (pick < 89) r.req_type = REQ_DISMISS;
            else if (pick < 98) r.req_type = REQ_SNOOZE;
            else r.req_type = REQ_UNKNOWN;
        end
        return r;
    endfunction

    function automatic t_req mk(logic [2:0] op, logic [31:0] id, logic [4:0] h,
                                logic [5:0] m, logic [7:0] d, logic [39:0] now);
        t_req r;
        r = '0;
        r.req_type = op; r.alarm_id = id; r.hour_value = h; r.minute_value = m;
        r.day_mask = d; r.now_seconds = now; r.time_valid = 1;
        r.enable_flag = 1; r.snooze_minutes = 1; r.weekday = 3;
        return r;
    endfunction

    initial begin
        t_req r;
        board = new();
        start = 0; i_req = '0; i_cfg_we = 0; i_cfg_wdata = 0;
        i_rst_n = 0; idle_ok = 1;
        clock_now = 40'd25200; last_id = 1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send(mk(REQ_ADD, 0, 24, 0, 0, 0));
        send(mk(REQ_ADD, 0, 0, 60, 0, 0));
        send(mk(REQ_ADD, 0, 0, 0, 8'h80, 0));
        send(mk(REQ_ADD, 0, 0, 0, 0, 0));
        send(mk(REQ_ADD, 0, 23, 59, 8'h7F, 0));
        send(mk(REQ_TICK, 0, 0, 0, 0, 0));
        send(mk(REQ_TICK, 0, 0, 0, 0, 40'd60));
        send(mk(REQ_SNOOZE, 0, 0, 0, 0, 40'd60));
        r = mk(REQ_SNOOZE, 0, 0, 0, 0, 40'd60); r.snooze_minutes = 0; send(r);
        r = mk(REQ_TICK, 0, 5, 5, 0, 40'd120); send(r);
        r = mk(REQ_TICK, 0, 5, 5, 0, 40'hFF_FFFF_FFFF); r.time_valid = 0; send(r);
        send(mk(REQ_UPDATE, 2, 23, 59, 8'h7F, 0));
        send(mk(REQ_UPDATE, 9, 1, 1, 0, 0));
        send(mk(REQ_ENABLE, 1, 0, 0, 0, 0));
        send(mk(REQ_TICK, 0, 23, 59, 0, 40'd1000));
        send(mk(REQ_TICK, 0, 23, 59, 0, 40'd100));
        send(mk(REQ_REMOVE, 2, 0, 0, 0, 0));
        send(mk(REQ_REMOVE, 2, 0, 0, 0, 0));
        send(mk(REQ_DISMISS, 0, 0, 0, 0, 0));
        send(mk(REQ_UNKNOWN, 0, 0, 0, 0, 0));
        for (int k = 0; k < 17; k++) send(mk(REQ_ADD, 0, 7, 0, 0, 0));

        write_timeout(16'd0);
        send(mk(REQ_TICK, 0, 7, 0, 0, 40'd25200));
        send(mk(REQ_TICK, 0, 7, 0, 0, 40'd25201));
        write_timeout(16'hFFFF);
        for (int k = 0; k < 16; k++) send(mk(REQ_REMOVE, k + 1, 0, 0, 0, 0));
        last_id = board.next_id;

        for (int n = 0; n < 900; n++) begin
            if (n == 300) write_timeout(16'd1);
            if (n == 600) write_timeout(16'($urandom_range(1, 300)));
            if (n == 450) drain();
            if (n == 750) idle_ok = 0;
            last_id = board.next_id;
            maybe_gap();
            send(rand_req());
        end

        drain();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
